[rtl/i2p_pkg.sv]
`timescale 1ns / 1ps

package i2p_pkg;

	// Default operator stack depth
	localparam int STACK_DEPTH_DEF = 32;

	// Character codes
	localparam logic [7:0] CH_CARET   = 8'h5E;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_LOW_A   = 8'h61;
	localparam logic [7:0] CH_LOW_Z   = 8'h7A;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;      // capture the input word
		logic emit;      // load the output register
		logic emit_top;  // emit the stack top instead of the held symbol
		logic pop;       // drop the stack top
		logic push;      // push the held symbol
		logic drop;      // push refused on a full stack
		logic run_last;  // last result of this input word
		logic done;      // final result of the expression
	} i2p_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic letter;    // held symbol is a lowercase letter
		logic last;      // held symbol ends the expression
		logic can_pop;   // top pops for the held symbol
		logic more_pop;  // entry below the top pops too
		logic empty;     // stack holds nothing
		logic one;       // stack holds exactly one entry
		logic full;      // stack holds STACK_DEPTH entries
		logic out_free;  // output register can take a word
	} i2p_stat_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= CH_LOW_A) && (c <= CH_LOW_Z);
	endfunction

	// Precedence rule: does the stacked top pop for the incoming symbol
	function automatic logic top_pops(input logic [7:0] top, input logic [7:0] inc);
		logic high_top;
		logic low_top;
		high_top = (top == CH_CARET) || (top == CH_STAR) ||
			(top == CH_SLASH) || (top == CH_PERCENT);
		low_top = (top == CH_PLUS) || (top == CH_MINUS);
		if (high_top) begin
			return inc != CH_CARET;
		end else if (low_top) begin
			return (inc == CH_PLUS) || (inc == CH_MINUS);
		end
		return 1'b0;
	endfunction

endpackage

[rtl/i2p_ram.sv]
`timescale 1ns / 1ps

module i2p_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, read one entry registered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

[rtl/i2p_ctrl.sv]
`timescale 1ns / 1ps

module i2p_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  i2p_pkg::i2p_stat_t  st,
	output i2p_pkg::i2p_cmd_t   cmd
);

	import i2p_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SCAN  = 3'b010,
		S_FLUSH = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	// Decode commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				if (st.letter) begin
					if (st.out_free) begin
						cmd.emit     = 1'b1;
						cmd.run_last = !(st.last && !st.empty);
						cmd.done     = st.last && st.empty;
						state_d      = (st.last && !st.empty) ? S_FLUSH : S_IDLE;
					end
				end else if (st.can_pop) begin
					if (st.out_free) begin
						cmd.emit     = 1'b1;
						cmd.emit_top = 1'b1;
						cmd.pop      = 1'b1;
						cmd.run_last = !st.more_pop && !st.last;
					end
				end else begin
					cmd.push = !st.full;
					cmd.drop = st.full;
					state_d  = st.last ? S_FLUSH : S_IDLE;
				end
			end
			S_FLUSH: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_top = 1'b1;
					cmd.pop      = 1'b1;
					cmd.run_last = st.one;
					cmd.done     = st.one;
					state_d      = st.one ? S_IDLE : S_FLUSH;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[rtl/i2p_dp.sv]
`timescale 1ns / 1ps

module i2p_dp #(
	parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         s_tdata,
	input  logic               s_tlast,
	input  i2p_pkg::i2p_cmd_t  cmd,
	output i2p_pkg::i2p_stat_t st,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,
	output logic               m_tlast,
	output logic [1:0]         m_tuser
);

	import i2p_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [7:0]    sym_q;
	logic          last_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic [7:0]    top_q;
	logic          ovf_q;
	logic [7:0]    second;
	logic [AW-1:0] rd_addr;
	logic          out_free;

	logic          out_valid_q;
	logic [7:0]    out_sym_q;
	logic          out_run_last_q;
	logic          out_done_q;
	logic          out_ovf_q;

	// Track the entry below the top: read address follows the next count
	always_comb begin
		count_d = count_q;
		if (cmd.push) begin
			count_d = count_q + CW'(1);
		end else if (cmd.pop) begin
			count_d = count_q - CW'(1);
		end
		rd_addr = '0;
		if (count_d >= CW'(2)) begin
			rd_addr = AW'(count_d - CW'(2));
		end
	end

	i2p_ram #(
		.WIDTH(8),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.wr_en  (cmd.push),
		.wr_addr(count_q[AW-1:0]),
		.wr_data(sym_q),
		.rd_addr(rd_addr),
		.rd_data(second)
	);

	// Hold the current input word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sym_q  <= s_tdata;
			last_q <= s_tlast;
		end
	end

	// Cache the stack top in a register
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			top_q <= sym_q;
		end else if (cmd.pop) begin
			top_q <= second;
		end
	end

	// Count entries and note dropped symbols
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			count_q <= count_d;
			if (cmd.drop) begin
				ovf_q <= 1'b1;
			end else if (cmd.emit && cmd.done) begin
				ovf_q <= 1'b0;
			end
		end
	end

	// Output register
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_sym_q      <= cmd.emit_top ? top_q : sym_q;
			out_run_last_q <= cmd.run_last;
			out_done_q     <= cmd.done;
			out_ovf_q      <= cmd.done && ovf_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_sym_q;
	assign m_tlast  = out_run_last_q;
	assign m_tuser  = {out_ovf_q, out_done_q};

	// Status to the controller
	always_comb begin
		st.letter   = is_letter(sym_q);
		st.last     = last_q;
		st.empty    = (count_q == '0);
		st.one      = (count_q == CW'(1));
		st.full     = (count_q == CW'(STACK_DEPTH));
		st.can_pop  = !st.empty && top_pops(top_q, sym_q);
		st.more_pop = (count_q >= CW'(2)) && top_pops(second, sym_q);
		st.out_free = out_free;
	end

`ifndef SYNTH
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> count_q != '0)
		else $error("pop on empty stack");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> count_q < CW'(STACK_DEPTH))
		else $error("push on full stack");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("output overwritten");

	a_push_pop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && cmd.pop))
		else $error("push and pop together");

	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_done_q) |-> out_run_last_q)
		else $error("expression end without run end");
`endif

endmodule

[rtl/infix_to_postfix_converter.sv]
// Infix to postfix converter, one character word in, postfix words out.
// Each accepted word is held in a register and its results leave through the output
// register. A new word is taken only in the idle state, once the pops for the previous
// word and, for a final word, the stack flush are done. Pops read the stack RAM one
// entry per cycle while the output register is free, with the top held in a register.
// Reset: arst_n clears the controller, stack count, overflow flag and output valid.
`timescale 1ns / 1ps

module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] symbol
	input  logic       s_tlast,   // expr_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_symbol
	output logic       m_tlast,   // run_last
	output logic [1:0] m_tuser    // [0] expr_done, [1] stack_overflow
);

	import i2p_pkg::*;

	i2p_cmd_t  cmd;
	i2p_stat_t st;

	i2p_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.st      (st),
		.cmd     (cmd)
	);

	i2p_dp #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.cmd     (cmd),
		.st      (st),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

endmodule

[dv/infix_to_postfix_converter_tb.sv]
`timescale 1ns / 1ps

module infix_to_postfix_converter_tb;

	import i2p_pkg::*;

	localparam int STACK_DEPTH  = STACK_DEPTH_DEF;
	localparam int DRAIN_CYCLES = 20;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;

	// How a generated character sequence marks its end
	typedef enum int {
		END_ON_FINAL,
		END_AT_RANDOM,
		END_NEVER
	} end_mode_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       run_last;
		logic       done;
		logic       ovf;
	} postfix_word_t;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // [7:0] symbol
	logic       s_tlast;   // expr_end
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // [7:0] out_symbol
	logic       m_tlast;   // run_last
	logic [1:0] m_tuser;   // [0] expr_done, [1] stack_overflow

	// Shadow of the operator stack and the sticky overflow flag
	logic [7:0] op_shadow [STACK_DEPTH];
	int         shadow_count;
	logic       shadow_ovf;

	postfix_word_t postfix_expected [$];

	int send_idle_pct;
	int recv_stall_pct;
	int rx_hold_left;
	int fail_count;
	int words_in;
	int words_out;
	int exprs_done;
	int ovf_reports;

	infix_to_postfix_converter #(
		.STACK_DEPTH(STACK_DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Precedence: does the stacked top leave before the incoming symbol
	function automatic logic pops_before(input logic [7:0] top, input logic [7:0] inc);
		case (top)
			CH_CARET, CH_STAR, CH_SLASH, CH_PERCENT: return inc != CH_CARET;
			CH_PLUS, CH_MINUS: return (inc == CH_PLUS) || (inc == CH_MINUS);
			default: return 1'b0;
		endcase
	endfunction

	// Work out the postfix words caused by one accepted input word
	function automatic void convert_symbol(input logic [7:0] sym, input logic last);
		postfix_word_t words [$];
		postfix_word_t w;
		int            k;
		w = '0;
		if (sym >= CH_LOW_A && sym <= CH_LOW_Z) begin
			w.ch = sym;
			words.push_back(w);
		end else begin
			while (shadow_count > 0 && pops_before(op_shadow[shadow_count - 1], sym)) begin
				shadow_count--;
				w.ch = op_shadow[shadow_count];
				words.push_back(w);
			end
			if (shadow_count < STACK_DEPTH) begin
				op_shadow[shadow_count] = sym;
				shadow_count++;
			end else begin
				shadow_ovf = 1'b1;
			end
		end
		// Flush the whole stack, top first
		if (last) begin
			while (shadow_count > 0) begin
				shadow_count--;
				w.ch = op_shadow[shadow_count];
				words.push_back(w);
			end
			k = words.size() - 1;
			w = words[k];
			w.done = 1'b1;
			w.ovf = shadow_ovf;
			words[k] = w;
			shadow_ovf = 1'b0;
		end
		if (words.size() > 0) begin
			k = words.size() - 1;
			w = words[k];
			w.run_last = 1'b1;
			words[k] = w;
		end
		foreach (words[i]) postfix_expected.push_back(words[i]);
	endfunction

	function automatic logic [7:0] pick_letter();
		return CH_LOW_A + 8'($urandom_range(25));
	endfunction

	function automatic logic [7:0] pick_operator();
		case ($urandom_range(5))
			0: return CH_CARET;
			1: return CH_STAR;
			2: return CH_SLASH;
			3: return CH_PERCENT;
			4: return CH_PLUS;
			default: return CH_MINUS;
		endcase
	endfunction

	// Offer one word, idling first as the current phase asks
	task automatic send_symbol(input logic [7:0] sym, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= sym;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		convert_symbol(sym, last);
		words_in++;
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++) send_symbol(s[i], i == s.len() - 1);
	endtask

	// Drop valid and wait until every expected word has come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (postfix_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Check each output word, then pick the next ready level
	always @(posedge clk) begin : rx_side
		postfix_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (postfix_expected.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %0h last %0b user %0b",
					$time, m_tdata, m_tlast, m_tuser);
				fail_count++;
			end else begin
				want = postfix_expected.pop_front();
				check_field("out_symbol", want.ch, m_tdata);
				check_field("run_last", {7'd0, want.run_last}, {7'd0, m_tlast});
				check_field("expr_done", {7'd0, want.done}, {7'd0, m_tuser[0]});
				check_field("stack_overflow", {7'd0, want.ovf}, {7'd0, m_tuser[1]});
				words_out++;
				if (m_tuser[0]) exprs_done++;
				if (m_tuser[0] && m_tuser[1]) ovf_reports++;
			end
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Every operator, associativity and precedence
	task automatic test_operators();
		send_string("a+b*c");
		send_string("a^b^c");
		send_string("a*b/c%d-e^f");
	endtask

	// Field extremes and codes just outside the letter range
	task automatic test_symbol_extremes();
		send_symbol(8'h00, 1'b0);
		send_symbol(8'hFF, 1'b0);
		send_symbol(CH_LOW_A - 8'd1, 1'b0);
		send_symbol(CH_LOW_Z + 8'd1, 1'b0);
		send_symbol(CH_LOW_A, 1'b0);
		send_symbol(CH_LOW_Z, 1'b1);
	endtask

	// Fill the stack exactly, then overrun it and flush the most words
	task automatic test_overflow();
		for (int i = 0; i < STACK_DEPTH - 1; i++) send_symbol(CH_CARET, 1'b0);
		send_symbol(CH_CARET, 1'b1);
		for (int i = 0; i < STACK_DEPTH + 1; i++) send_symbol(CH_LPAREN, 1'b0);
		send_symbol(CH_PLUS, 1'b0);
		send_symbol(pick_letter(), 1'b1);
		send_string("a-b");
	endtask

	// Hold the receiver off while words keep coming
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		rx_hold_left = 400;
		send_string("a+b-c*d+e-f*g+h-i*j+k-l*m+n");
		wait_drained();
	endtask

	// One random sequence: mostly well formed, some chains, noise and fragments
	task automatic send_random_expression();
		logic [7:0] chars [$];
		end_mode_t  mode;
		int         kind;
		int         n;
		int         depth;
		logic       last;
		kind = $urandom_range(99);
		mode = END_ON_FINAL;
		depth = 0;
		if (kind < 70) begin
			n = $urandom_range(1, 8);
			for (int i = 0; i < n; i++) begin
				if (i > 0) chars.push_back(pick_operator());
				if ($urandom_range(99) < 20) begin
					chars.push_back(CH_LPAREN);
					depth++;
				end
				chars.push_back(pick_letter());
				if (depth > 0 && $urandom_range(99) < 30) begin
					chars.push_back(CH_RPAREN);
					depth--;
				end
			end
			while (depth > 0) begin
				chars.push_back(CH_RPAREN);
				depth--;
			end
		end else if (kind < 78) begin
			// Right-associative chain near the stack depth; the longer ones reach the full stack
			n = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 4);
			chars.push_back(pick_letter());
			for (int i = 1; i < n; i++) begin
				chars.push_back(CH_CARET);
				chars.push_back(pick_letter());
			end
		end else if (kind < 90) begin
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++) chars.push_back(8'($urandom_range(255)));
			mode = END_AT_RANDOM;
		end else begin
			n = $urandom_range(1, 10);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(2))
					0: chars.push_back(pick_letter());
					1: chars.push_back(pick_operator());
					default: chars.push_back($urandom_range(1) ? CH_LPAREN : CH_RPAREN);
				endcase
			end
			mode = $urandom_range(1) ? END_ON_FINAL : END_NEVER;
		end
		for (int i = 0; i < chars.size(); i++) begin
			if (mode == END_AT_RANDOM) last = ($urandom_range(3) == 0);
			else last = (mode == END_ON_FINAL) && (i == chars.size() - 1);
			send_symbol(chars[i], last);
		end
	endtask

	// Random phases with different idling on each side
	task automatic test_random();
		int idle_s [4] = '{0, 47, 0, 12};
		int idle_r [4] = '{0, 0, 47, 12};
		int start;
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_s[p];
			recv_stall_pct = idle_r[p];
			start = words_in;
			while (words_in - start < 15) send_random_expression();
		end
	endtask

	initial begin
		arst_n         <= 1'b0;
		s_tvalid       <= 1'b0;
		s_tdata        <= 8'd0;
		s_tlast        <= 1'b0;
		m_tready       <= 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		rx_hold_left   = 0;
		fail_count     = 0;
		words_in       = 0;
		words_out      = 0;
		exprs_done     = 0;
		ovf_reports    = 0;
		shadow_count   = 0;
		shadow_ovf     = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_operators();
		test_symbol_extremes();
		send_idle_pct = 12;
		recv_stall_pct = 12;
		test_overflow();
		test_backpressure();
		test_random();
		wait_drained();

		$display("Sent %0d input words, checked %0d postfix words over %0d expressions.",
			words_in, words_out, exprs_done);
		$display("Stack overflow reported %0d times; backpressure hold and idle phases run.",
			ovf_reports);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
